>>> hdl/ssp_pkg.sv
// Shared types and constants for the sprite screen projection block.
`default_nettype none
package ssp_pkg;

	// Configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_FIELD_OF_VIEW = 2'd2;

	// Configuration reset values
	localparam logic [12:0] FRAME_WIDTH_RST   = 13'd640;
	localparam logic [12:0] FRAME_HEIGHT_RST  = 13'd480;
	localparam logic [15:0] FIELD_OF_VIEW_RST = 16'd10813;

	// Quotient bits of the depth / lateral dividers and of the center / size dividers
	localparam int TQ_BITS = 41;
	localparam int CQ_BITS = 16;

	// One result item
	typedef struct packed {
		logic signed [31:0] depth;
		logic signed [15:0] center_column;
		logic [15:0]        sprite_height;
		logic [15:0]        sprite_width;
		logic [14:0]        column_begin;
		logic signed [15:0] column_end;
		logic [14:0]        row_begin;
		logic signed [15:0] row_end;
		logic               degenerate;
	} res_t;

endpackage
`default_nettype wire

>>> hdl/ssp_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none
module ssp_div #(
	parameter int AW = 73,
	parameter int DW = 32,
	parameter int QW = 41,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [AW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [QW-1:0]      quo,
	output logic               ovf,
	output logic [SW-1:0]      side_out
);

	logic          v_s    [QW+1];
	logic [DW-1:0] rem_s  [QW+1];
	logic [QW-1:0] nq_s   [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic          ovf_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];

	logic              ovf_c;
	logic [QW+DW-1:0]  low_c;

	// quotient would not fit in QW bits
	assign ovf_c = num >= (AW'(den) << QW);
	assign low_c = num[QW+DW-1:0];

	// stage 0: load remainder and numerator tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= low_c[QW+DW-1:QW];
			nq_s[0]   <= low_c[QW-1:0];
			den_s[0]  <= den;
			ovf_s[0]  <= ovf_c;
			side_s[0] <= side_in;
		end
	end

	// one quotient bit per stage; numerator bits shift out as quotient bits shift in
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		assign trial = {rem_s[k-1], nq_s[k-1][QW-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				nq_s[k]   <= {nq_s[k-1][QW-2:0], ge};
				den_s[k]  <= den_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = nq_s[QW];
	assign ovf       = ovf_s[QW];
	assign side_out  = side_s[QW];

endmodule
`default_nettype wire

>>> hdl/sprite_screen_projection.sv
// Sprite camera projection pipeline: depth, center column, size and clamped draw spans.
//
// One item is accepted per clock cycle unless both output entries are full and the output
// is not taken. Two pairs of pipelined dividers resolve one quotient bit per stage: 41 bits
// for depth and lateral ratio, 16 bits for center column and sprite size. A two-entry output
// buffer (output register plus skid) keeps items flowing while a result waits; with both
// entries full the whole pipeline holds. Configuration is written over a 4-bit APB address
// (registers at 0x0, 0x4, 0x8) and takes effect at once, also for items already in the
// pipeline; write it only while the block is idle.
`default_nettype none
module sprite_screen_projection
	import ssp_pkg::*;
#(
	parameter int POS_FRAC_BITS = 16,
	parameter int SCREEN_BITS   = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// input items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] obj_x,
	input  wire logic signed [31:0] obj_y,
	input  wire logic signed [31:0] player_x,
	input  wire logic signed [31:0] player_y,
	input  wire logic signed [15:0] dir_x,
	input  wire logic signed [15:0] dir_y,
	input  wire logic signed [15:0] plane_x,
	input  wire logic signed [15:0] plane_y,
	input  wire logic [11:0]        horizon_row,
	// result items
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      depth,
	output logic signed [15:0]      center_column,
	output logic [15:0]             sprite_height,
	output logic [15:0]             sprite_width,
	output logic [14:0]             column_begin,
	output logic signed [15:0]      column_end,
	output logic [14:0]             row_begin,
	output logic signed [15:0]      row_end,
	output logic                    degenerate
);

	localparam int WW   = SCREEN_BITS + 1;       // clamped frame size
	localparam int HW   = SCREEN_BITS;           // half width, horizon
	localparam int SMAX = 1 << SCREEN_BITS;
	localparam int NUMW = SCREEN_BITS + 43;      // center numerator, signed
	localparam int DAW  = TQ_BITS + 32;
	localparam int TAW  = TQ_BITS + 50;
	localparam int ZAW  = CQ_BITS + 48;
	localparam int DSW  = 2 + HW;
	localparam int CSW  = 33 + HW;

	// ---------------- configuration registers ----------------
	logic [12:0] fw_q;
	logic [12:0] fh_q;
	logic [15:0] fov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FRAME_WIDTH_RST;
			fh_q  <= FRAME_HEIGHT_RST;
			fov_q <= FIELD_OF_VIEW_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_FRAME_WIDTH:   fw_q  <= pwdata[12:0];
				REG_FRAME_HEIGHT:  fh_q  <= pwdata[12:0];
				REG_FIELD_OF_VIEW: fov_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FRAME_WIDTH:   prdata = {19'd0, fw_q};
			REG_FRAME_HEIGHT:  prdata = {19'd0, fh_q};
			REG_FIELD_OF_VIEW: prdata = {16'd0, fov_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;

	// effective frame size, half width and fov
	logic [15:0]   fw_x, fh_x;
	logic [WW-1:0] w, h;
	logic [HW-1:0] half;
	logic [15:0]   fov_e;
	logic [15:0]   hz_x;

	assign fw_x  = (fw_q == '0) ? 16'd1 :
	               ({3'd0, fw_q} > 16'(SMAX)) ? 16'(SMAX) : {3'd0, fw_q};
	assign fh_x  = (fh_q == '0) ? 16'd1 :
	               ({3'd0, fh_q} > 16'(SMAX)) ? 16'(SMAX) : {3'd0, fh_q};
	assign w     = fw_x[WW-1:0];
	assign h     = fh_x[WW-1:0];
	assign half  = w[WW-1:1];
	assign fov_e = (fov_q == '0) ? 16'd1 : fov_q;
	assign hz_x  = {4'd0, horizon_row};

	// ---------------- pipeline control ----------------
	logic en;
	logic o_valid_q, k_valid_q;
	logic pop;

	assign pop      = o_valid_q && out_ready;
	assign en       = !k_valid_q || pop;
	assign in_ready = en;

	// ---------------- stages 1..4: offsets, matrix products, magnitudes ----------------
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [32:0]   dx_s1, dy_s1;
	logic signed [31:0]   pa_s1, pb_s1;
	logic signed [15:0]   drx_s1, dry_s1, pnx_s1, pny_s1;
	logic [HW-1:0]        hz_s1, hz_s2, hz_s3, hz_s4;
	logic signed [32:0]   det_s2, det_s3;
	logic signed [48:0]   m1_s2, m2_s2, m3_s2, m4_s2;
	logic signed [49:0]   nx_s3, nd_s3;
	logic [63:0]          dnum_s4, tnum_s4;
	logic [31:0]          dden_s4;
	logic [49:0]          tden_s4;
	logic                 sd_s4, st_s4, detz_s4;

	logic [32:0] det_abs;
	logic [49:0] nd_abs, nx_abs;

	assign det_abs = det_s3[32] ? 33'(-det_s3) : 33'(det_s3);
	assign nd_abs  = nd_s3[49] ? 50'(-nd_s3) : 50'(nd_s3);
	assign nx_abs  = nx_s3[49] ? 50'(-nx_s3) : 50'(nx_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: viewer-to-sprite offset, determinant products
			dx_s1  <= {obj_x[31], obj_x} - {player_x[31], player_x};
			dy_s1  <= {obj_y[31], obj_y} - {player_y[31], player_y};
			pa_s1  <= plane_x * dir_y;
			pb_s1  <= dir_x * plane_y;
			drx_s1 <= dir_x;
			dry_s1 <= dir_y;
			pnx_s1 <= plane_x;
			pny_s1 <= plane_y;
			hz_s1  <= hz_x[HW-1:0];
			// s2: inverse matrix products
			det_s2 <= pa_s1 - pb_s1;
			m1_s2  <= dry_s1 * dx_s1;
			m2_s2  <= drx_s1 * dy_s1;
			m3_s2  <= pnx_s1 * dy_s1;
			m4_s2  <= pny_s1 * dx_s1;
			hz_s2  <= hz_s1;
			// s3: lateral and depth numerators
			nx_s3  <= m1_s2 - m2_s2;
			nd_s3  <= m3_s2 - m4_s2;
			det_s3 <= det_s2;
			hz_s3  <= hz_s2;
			// s4: sign and magnitude for the dividers
			dnum_s4 <= {nd_abs, 14'd0};
			dden_s4 <= det_abs[31:0];
			tnum_s4 <= {nx_abs, 14'd0};
			tden_s4 <= nd_abs;
			sd_s4   <= nd_s3[49] ^ det_s3[32];
			st_s4   <= nx_s3[49] ^ nd_s3[49];
			detz_s4 <= (det_s3 == '0);
			hz_s4   <= hz_s3;
		end
	end

	// ---------------- depth and lateral ratio dividers ----------------
	logic               dv, tv, dovf, tovf;
	logic [TQ_BITS-1:0] dq, tq;
	logic [DSW-1:0]     dside;
	logic               tside;

	ssp_div #(.AW(DAW), .DW(32), .QW(TQ_BITS), .SW(DSW)) u_div_depth (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num      (DAW'(dnum_s4)),
		.den      (dden_s4),
		.side_in  ({detz_s4, sd_s4, hz_s4}),
		.out_valid(dv),
		.quo      (dq),
		.ovf      (dovf),
		.side_out (dside)
	);

	ssp_div #(.AW(TAW), .DW(50), .QW(TQ_BITS), .SW(1)) u_div_lat (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num      (TAW'(tnum_s4)),
		.den      (tden_s4),
		.side_in  (st_s4),
		.out_valid(tv),
		.quo      (tq),
		.ovf      (tovf),
		.side_out (tside)
	);

	// ---------------- stages 5..7: saturate, scale, center numerator ----------------
	logic                  v_s5, v_s6, v_s7;
	logic signed [31:0]    depth_s5, depth_s6, depth_s7;
	logic signed [41:0]    t_s5;
	logic                  deg_s5, deg_s6, deg_s7;
	logic [HW-1:0]         hz_s5, hz_s6, hz_s7;
	logic [47:0]           den_s6, den_s7;
	logic signed [NUMW-1:0] ht_s6;
	logic [HW+15:0]        hf_s6;
	logic [NUMW-1:0]       cnum_s7;
	logic                  cs_s7;

	logic                   d_neg, d_sat, d_deg;
	logic signed [31:0]     depth_c;
	logic [TQ_BITS-1:0]     tm;
	logic [31:0]            ad;
	logic signed [NUMW-1:0] num_c;

	assign d_neg   = dside[HW];
	assign d_sat   = dovf || (d_neg ? (dq > 41'h80000000) : (dq > 41'h7FFFFFFF));
	assign d_deg   = dside[HW+1] || (!dovf && dq == '0);
	assign depth_c = d_deg ? 32'sd0 :
	                 d_sat ? (d_neg ? 32'sh80000000 : 32'sh7FFFFFFF) :
	                 (d_neg ? -$signed(dq[31:0]) : $signed(dq[31:0]));
	// lateral ratio is clamped to +-2^40
	assign tm      = (tovf || tq > 41'h10000000000) ? 41'h10000000000 : tq;
	assign ad      = depth_s5[31] ? 32'(-depth_s5) : 32'(depth_s5);
	assign num_c   = $signed(NUMW'(hf_s6)) + (ht_s6 <<< 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv && tv;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s5
			depth_s5 <= depth_c;
			t_s5     <= tside ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
			deg_s5   <= d_deg;
			hz_s5    <= dside[HW-1:0];
			// s6
			den_s6   <= fov_e * ad;
			ht_s6    <= $signed({1'b0, half}) * t_s5;
			hf_s6    <= half * fov_e;
			depth_s6 <= depth_s5;
			deg_s6   <= deg_s5;
			hz_s6    <= hz_s5;
			// s7
			cnum_s7  <= num_c[NUMW-1] ? NUMW'(-num_c) : NUMW'(num_c);
			cs_s7    <= num_c[NUMW-1];
			den_s7   <= den_s6;
			depth_s7 <= depth_s6;
			deg_s7   <= deg_s6;
			hz_s7    <= hz_s6;
		end
	end

	// ---------------- center column and size dividers ----------------
	logic               cv, zv, covf, zovf;
	logic [CQ_BITS-1:0] cq, zq;
	logic [CSW-1:0]     cside;
	logic               zside;

	ssp_div #(.AW(NUMW), .DW(16), .QW(CQ_BITS), .SW(CSW)) u_div_center (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s7),
		.num      (cnum_s7),
		.den      (fov_e),
		.side_in  ({cs_s7, depth_s7, hz_s7}),
		.out_valid(cv),
		.quo      (cq),
		.ovf      (covf),
		.side_out (cside)
	);

	ssp_div #(.AW(ZAW), .DW(48), .QW(CQ_BITS), .SW(1)) u_div_size (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s7),
		.num      (ZAW'(w) << (14 + POS_FRAC_BITS)),
		.den      (den_s7),
		.side_in  (deg_s7),
		.out_valid(zv),
		.quo      (zq),
		.ovf      (zovf),
		.side_out (zside)
	);

	// ---------------- stage 8: center and size saturation ----------------
	logic               v_s8;
	logic signed [15:0] center_s8;
	logic [15:0]        size_s8;
	logic signed [31:0] depth_s8;
	logic               deg_s8;
	logic [HW-1:0]      hz_s8;

	logic c_neg, c_sat;

	assign c_neg = cside[HW+32];
	assign c_sat = covf || (c_neg ? (cq > 16'h8000) : (cq > 16'h7FFF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= cv && zv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			center_s8 <= zside ? $signed(16'(half)) :
			             c_sat ? (c_neg ? 16'sh8000 : 16'sh7FFF) :
			             (c_neg ? -$signed(cq) : $signed(cq));
			size_s8   <= (zside || zovf) ? 16'hFFFF : zq;
			depth_s8  <= $signed(cside[HW+31:HW]);
			deg_s8    <= zside;
			hz_s8     <= cside[HW-1:0];
		end
	end

	// ---------------- draw spans ----------------
	res_t        res_c;
	logic [14:0] hs;
	logic [17:0] cb18, ce18, cew18, w18;
	logic [16:0] rb17, re17, h17;

	assign hs    = size_s8[15:1];
	assign w18   = 18'(w);
	assign h17   = 17'(h);
	assign cb18  = 18'(center_s8) - 18'(hs);
	assign ce18  = 18'(center_s8) + 18'(hs);
	assign cew18 = (!ce18[17] && ce18 >= w18) ? w18 : ce18;
	assign rb17  = 17'(hz_s8) - 17'(hs);
	assign re17  = 17'(hz_s8) + 17'(hs);

	always_comb begin
		res_c.depth         = depth_s8;
		res_c.center_column = center_s8;
		res_c.sprite_height = size_s8;
		res_c.sprite_width  = size_s8;
		res_c.column_begin  = cb18[17] ? 15'd0 : cb18[14:0];
		res_c.column_end    = (!cew18[17] && cew18 > 18'd32767) ? 16'sh7FFF
		                      : $signed(cew18[15:0]);
		res_c.row_begin     = rb17[16] ? 15'd0 : rb17[14:0];
		res_c.row_end       = (re17 > h17) ? $signed(h17[15:0]) : $signed(re17[15:0]);
		res_c.degenerate    = deg_s8;
	end

	// ---------------- output register and skid ----------------
	res_t o_q, k_q;
	logic push;

	assign push = en && v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			k_valid_q <= 1'b0;
		end else if (pop || !o_valid_q) begin
			o_valid_q <= k_valid_q || push;
			k_valid_q <= k_valid_q && push;
		end else if (push) begin
			k_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !o_valid_q) begin
			o_q <= k_valid_q ? k_q : res_c;
			if (k_valid_q) begin
				k_q <= res_c;
			end
		end else if (push) begin
			k_q <= res_c;
		end
	end

	assign out_valid     = o_valid_q;
	assign depth         = o_q.depth;
	assign center_column = o_q.center_column;
	assign sprite_height = o_q.sprite_height;
	assign sprite_width  = o_q.sprite_width;
	assign column_begin  = o_q.column_begin;
	assign column_end    = o_q.column_end;
	assign row_begin     = o_q.row_begin;
	assign row_end       = o_q.row_end;
	assign degenerate    = o_q.degenerate;

`ifndef ASSERT_OFF
	// skid entry only fills behind a held output item
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		k_valid_q |-> o_valid_q)
		else $error("skid entry valid without output item");

	// input is refused only when both output entries are full
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (k_valid_q && o_valid_q && !out_ready))
		else $error("input refused with room in output buffer");

	// degenerate geometry gives zero depth and full size
	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (depth == 32'sd0 && sprite_height == 16'hFFFF))
		else $error("degenerate item not saturated");

	// width and height track each other
	a_square: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sprite_width == sprite_height))
		else $error("sprite width differs from height");
`endif

endmodule
`default_nettype wire
